// ===== hdl/pmle_pkg.sv =====
// types, sizes and codes shared by the progressive mesh level engine
// no dependencies
package pmle_pkg;

    localparam int SUBMESHES     = 4;
    localparam int SUB_W         = 2;
    localparam int MAX_INDICES   = 4096;
    localparam int IDX_W         = 12;
    localparam int CNT_W         = 13;
    localparam int MAX_SPLITS    = 1024;
    localparam int SPL_W         = 10;
    localparam int LVL_W         = 11;
    localparam int MAX_ADDITIONS = 4096;
    localparam int ADD_W         = 12;
    localparam int MAX_MOVES     = 4096;
    localparam int MOV_W         = 12;
    localparam int ST_W          = 13;
    localparam int VW            = 16;

    typedef enum logic [2:0] {
        CMD_LOAD_BASE = 3'd0,
        CMD_BASE_CNT  = 3'd1,
        CMD_HEADER    = 3'd2,
        CMD_ADDITION  = 3'd3,
        CMD_MOVE      = 3'd4,
        CMD_LEVEL     = 3'd5,
        CMD_READ      = 3'd6,
        CMD_NOP       = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNMATCHED = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_FIT_RD, S_FIT_CHK, S_CP_RD, S_CP_WR,
        S_SPL_RD, S_SPL_HDR, S_ADD_RD, S_ADD_W0, S_ADD_W1, S_ADD_W2,
        S_MV_RD, S_MV_LAT, S_TRI_RD0, S_TRI_RD1, S_TRI_RD2, S_TRI_CHK,
        S_TRI_W1, S_TRI_W2, S_SPL_END, S_POST
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  submesh;
        logic [11:0] slot;
        logic [12:0] count;
        logic [15:0] vert_a;
        logic [15:0] vert_b;
        logic [15:0] vert_c;
        logic [15:0] from_vertex;
        logic [15:0] to_vertex;
        logic [7:0]  num_additions;
        logic [7:0]  num_moves;
        logic [10:0] target_level;
    } t_in;

    typedef struct packed {
        logic [15:0] read_value;
        logic [12:0] index_count;
        logic [10:0] current_level;
        logic [2:0]  status;
    } t_out;

    typedef struct packed {
        logic [SUB_W-1:0] sub;
        logic [7:0]       nadd;
        logic [7:0]       nmov;
        logic [ST_W-1:0]  add_start;
        logic [ST_W-1:0]  mov_start;
    } t_hdr;

    typedef struct packed {
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        logic [VW-1:0] c;
    } t_tri;

    typedef struct packed {
        t_tri          pat;
        logic [VW-1:0] fv;
        logic [VW-1:0] tv;
    } t_move;

endpackage

// ===== hdl/progressive_mesh_level_engine_core.sv =====
// progressive mesh level engine: loads, reads and level walks over ram stores
// load and nop items are answered at once, a read item after its ram read; a level item runs
// a fit pass when going up, an uncached base copy of every submesh, then per split its
// additions (forward only) and its moves, each move searching triangles through the single
// read port of the working index ram, and closes with the result. reset is synchronous
// active low, clears counts, level and cached flag; the stores hold no reset value
module progressive_mesh_level_engine_core
    import pmle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int WA_W = SUB_W + IDX_W;

    // control and counts
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_base_cnt [SUBMESHES];
    logic [CNT_W-1:0] n_base_cnt [SUBMESHES];
    logic [CNT_W-1:0] r_work_cnt [SUBMESHES];
    logic [CNT_W-1:0] n_work_cnt [SUBMESHES];
    logic [CNT_W:0]   r_tmp [SUBMESHES];
    logic [CNT_W:0]   n_tmp [SUBMESHES];
    logic [LVL_W-1:0] r_splits, n_splits;
    logic [ST_W-1:0]  r_adds, n_adds, r_movs, n_movs;
    logic [LVL_W-1:0] r_level, n_level;
    logic             r_cached, n_cached;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    // walk state
    logic [SUB_W-1:0] r_sm, n_sm;
    logic [LVL_W-1:0] r_target, n_target, r_s, n_s, r_from, n_from;
    logic             r_fwd, n_fwd, r_ok, n_ok, r_done, n_done, r_zero, n_zero;
    logic [2:0]       r_status, n_status;
    logic [SUB_W-1:0] r_cp_sm, n_cp_sm;
    logic [CNT_W-1:0] r_cp_i, n_cp_i;
    t_hdr             r_h, n_h;
    logic [CNT_W-1:0] r_cnt, n_cnt, r_bound, n_bound, r_i, n_i;
    logic [7:0]       r_j, n_j;
    t_tri             r_p, n_p, r_addw, n_addw;
    logic [VW-1:0]    r_old, n_old, r_new, n_new, r_t0, n_t0, r_t1, n_t1, r_t2, n_t2;

    // ram ports
    logic             base_we, work_we, hdr_we, add_we, mov_we;
    logic [WA_W-1:0]  base_waddr, base_raddr, work_waddr, work_raddr;
    logic [VW-1:0]    base_wdata, base_rdata, work_wdata, work_rdata;
    logic [SPL_W-1:0] hdr_waddr, hdr_raddr;
    t_hdr             hdr_wdata, hdr_rdata;
    logic [ADD_W-1:0] add_waddr, add_raddr;
    t_tri             add_wdata, add_rdata;
    logic [MOV_W-1:0] mov_waddr, mov_raddr;
    t_move            mov_wdata, mov_rdata;

    pmle_ram #(.WIDTH(VW), .DEPTH(SUBMESHES * MAX_INDICES)) u_base (
        .i_clk(i_clk), .i_we(base_we), .i_waddr(base_waddr), .i_wdata(base_wdata),
        .i_raddr(base_raddr), .o_rdata(base_rdata));
    pmle_ram #(.WIDTH(VW), .DEPTH(SUBMESHES * MAX_INDICES)) u_work (
        .i_clk(i_clk), .i_we(work_we), .i_waddr(work_waddr), .i_wdata(work_wdata),
        .i_raddr(work_raddr), .o_rdata(work_rdata));
    pmle_ram #(.WIDTH($bits(t_hdr)), .DEPTH(MAX_SPLITS)) u_hdr (
        .i_clk(i_clk), .i_we(hdr_we), .i_waddr(hdr_waddr), .i_wdata(hdr_wdata),
        .i_raddr(hdr_raddr), .o_rdata(hdr_rdata));
    pmle_ram #(.WIDTH($bits(t_tri)), .DEPTH(MAX_ADDITIONS)) u_add (
        .i_clk(i_clk), .i_we(add_we), .i_waddr(add_waddr), .i_wdata(add_wdata),
        .i_raddr(add_raddr), .o_rdata(add_rdata));
    pmle_ram #(.WIDTH($bits(t_move)), .DEPTH(MAX_MOVES)) u_mov (
        .i_clk(i_clk), .i_we(mov_we), .i_waddr(mov_waddr), .i_wdata(mov_wdata),
        .i_raddr(mov_raddr), .o_rdata(mov_rdata));

    // shared decisions
    logic             acc;
    logic             lvl_bad, lvl_same, lvl_down, rd_bad;
    logic [CNT_W:0]   fit_sum;
    logic             fit_more, fit_fail, cp_more, cp_last, spl_more;
    logic [ST_W:0]    add_idx, mov_idx;
    logic             add_more, mv_more, tri_match, tri_more;
    logic [9:0]       drop;
    t_move            mv;

    // the output slot is free when empty or being taken this cycle
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign acc        = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign lvl_bad  = i_in.target_level > r_splits;
    assign lvl_same = r_cached && (i_in.target_level == r_level);
    assign lvl_down = r_cached && (i_in.target_level < r_level);
    assign rd_bad   = {1'b0, i_in.slot} >= r_work_cnt[i_in.submesh];

    // fit pass: accumulate per-submesh counts over the splits to be walked
    assign fit_more = r_s < r_target;
    assign fit_sum  = r_tmp[hdr_rdata.sub] + (CNT_W+1)'(10'(hdr_rdata.nadd) * 10'd3);
    assign fit_fail = fit_sum > (CNT_W+1)'(MAX_INDICES);
    assign cp_more  = r_cp_i < r_base_cnt[r_cp_sm];
    assign cp_last  = r_cp_sm == SUB_W'(SUBMESHES - 1);
    assign spl_more = r_fwd ? (r_s < r_target) : (r_s > r_target);
    assign add_idx  = {1'b0, r_h.add_start} + (ST_W+1)'(r_j);
    assign mov_idx  = {1'b0, r_h.mov_start} + (ST_W+1)'(r_j);
    assign add_more = (r_j < r_h.nadd) &&
                      ({1'b0, r_cnt} + (CNT_W+1)'(3) <= (CNT_W+1)'(MAX_INDICES));
    assign mv_more  = r_j < r_h.nmov;
    assign tri_match = (r_t0 == r_p.a) && (r_t1 == r_p.b) && (work_rdata == r_p.c);
    assign tri_more  = {1'b0, r_i} + (CNT_W+1)'(6) <= {1'b0, r_bound};
    assign drop      = 10'(r_h.nadd) * 10'd3;
    // entries past the end of their store read as zero
    assign mv        = r_zero ? '0 : mov_rdata;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_in.cmd == CMD_READ && !rd_bad) begin
                        n_state = S_READ;
                    end else if (i_in.cmd == CMD_LEVEL && !lvl_bad && !lvl_same) begin
                        n_state = lvl_down ? S_SPL_RD : S_FIT_RD;
                    end
                end
            end
            S_READ:    n_state = S_IDLE;
            S_FIT_RD: begin
                if (fit_more) n_state = S_FIT_CHK;
                else          n_state = r_cached ? S_SPL_RD : S_CP_RD;
            end
            S_FIT_CHK: n_state = fit_fail ? S_POST : S_FIT_RD;
            S_CP_RD: begin
                if (cp_more)      n_state = S_CP_WR;
                else if (cp_last) n_state = S_SPL_RD;
            end
            S_CP_WR:   n_state = S_CP_RD;
            S_SPL_RD:  n_state = spl_more ? S_SPL_HDR : S_POST;
            S_SPL_HDR: n_state = r_fwd ? S_ADD_RD : S_MV_RD;
            S_ADD_RD:  n_state = add_more ? S_ADD_W0 : S_MV_RD;
            S_ADD_W0:  n_state = S_ADD_W1;
            S_ADD_W1:  n_state = S_ADD_W2;
            S_ADD_W2:  n_state = S_ADD_RD;
            S_MV_RD:   n_state = mv_more ? S_MV_LAT : S_SPL_END;
            S_MV_LAT:  n_state = (r_bound < CNT_W'(3)) ? S_MV_RD : S_TRI_RD0;
            S_TRI_RD0: n_state = S_TRI_RD1;
            S_TRI_RD1: n_state = S_TRI_RD2;
            S_TRI_RD2: n_state = S_TRI_CHK;
            S_TRI_CHK: begin
                if (tri_match)     n_state = S_TRI_W1;
                else if (tri_more) n_state = S_TRI_RD0;
                else               n_state = S_MV_RD;
            end
            S_TRI_W1:  n_state = S_TRI_W2;
            S_TRI_W2:  n_state = S_MV_RD;
            S_SPL_END: n_state = S_SPL_RD;
            S_POST:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and ram controls
    always_comb begin
        n_base_cnt = r_base_cnt;  n_work_cnt = r_work_cnt;  n_tmp = r_tmp;
        n_splits = r_splits;  n_adds = r_adds;  n_movs = r_movs;
        n_level = r_level;  n_cached = r_cached;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_sm = r_sm;  n_target = r_target;  n_s = r_s;  n_from = r_from;
        n_fwd = r_fwd;  n_ok = r_ok;  n_done = r_done;  n_zero = r_zero;
        n_status = r_status;  n_cp_sm = r_cp_sm;  n_cp_i = r_cp_i;
        n_h = r_h;  n_cnt = r_cnt;  n_bound = r_bound;  n_i = r_i;  n_j = r_j;
        n_p = r_p;  n_addw = r_addw;  n_old = r_old;  n_new = r_new;
        n_t0 = r_t0;  n_t1 = r_t1;  n_t2 = r_t2;

        base_we = 1'b0;  base_waddr = {i_in.submesh, i_in.slot};  base_wdata = i_in.vert_a;
        base_raddr = {r_cp_sm, r_cp_i[IDX_W-1:0]};
        work_we = 1'b0;  work_waddr = {r_h.sub, r_cnt[IDX_W-1:0]};  work_wdata = r_new;
        work_raddr = {i_in.submesh, i_in.slot};
        hdr_we = 1'b0;  hdr_waddr = r_splits[SPL_W-1:0];
        hdr_wdata = '{sub: i_in.submesh, nadd: i_in.num_additions,
                      nmov: i_in.num_moves, add_start: r_adds, mov_start: r_movs};
        hdr_raddr = r_fwd ? r_s[SPL_W-1:0] : SPL_W'(r_s - LVL_W'(1));
        add_we = 1'b0;  add_waddr = r_adds[ADD_W-1:0];
        add_wdata = '{a: i_in.vert_a, b: i_in.vert_b, c: i_in.vert_c};
        add_raddr = add_idx[ADD_W-1:0];
        mov_we = 1'b0;  mov_waddr = r_movs[MOV_W-1:0];
        mov_wdata = '{pat: '{a: i_in.vert_a, b: i_in.vert_b, c: i_in.vert_c},
                      fv: i_in.from_vertex, tv: i_in.to_vertex};
        mov_raddr = mov_idx[MOV_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_sm = i_in.submesh;
                    n_target = i_in.target_level;
                    // immediate result; loads leave working counts and level alone
                    n_out_valid = 1'b1;
                    n_out = '{read_value: '0, index_count: r_work_cnt[i_in.submesh],
                              current_level: r_level, status: ST_OK};
                    case (i_in.cmd)
                        CMD_LOAD_BASE: begin
                            base_we = 1'b1;
                            n_cached = 1'b0;
                        end
                        CMD_BASE_CNT: begin
                            if (i_in.count > CNT_W'(MAX_INDICES)) begin
                                n_out.status = ST_RANGE;
                            end else begin
                                n_base_cnt[i_in.submesh] = i_in.count;
                                n_cached = 1'b0;
                            end
                        end
                        CMD_HEADER: begin
                            if (r_splits >= LVL_W'(MAX_SPLITS)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                hdr_we = 1'b1;
                                n_splits = r_splits + LVL_W'(1);
                                n_cached = 1'b0;
                            end
                        end
                        CMD_ADDITION: begin
                            if (r_adds >= ST_W'(MAX_ADDITIONS)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                add_we = 1'b1;
                                n_adds = r_adds + ST_W'(1);
                                n_cached = 1'b0;
                            end
                        end
                        CMD_MOVE: begin
                            if (r_movs >= ST_W'(MAX_MOVES)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                mov_we = 1'b1;
                                n_movs = r_movs + ST_W'(1);
                                n_cached = 1'b0;
                            end
                        end
                        CMD_LEVEL: begin
                            if (lvl_bad) begin
                                n_out.status = ST_RANGE;
                            end else if (!lvl_same) begin
                                n_out_valid = 1'b0;
                                n_ok = 1'b1;
                                if (lvl_down) begin
                                    n_fwd = 1'b0;
                                    n_s = r_level;
                                end else begin
                                    n_fwd = 1'b1;
                                    n_s = r_cached ? r_level : '0;
                                    n_from = r_cached ? r_level : '0;
                                    for (int k = 0; k < SUBMESHES; k++) begin
                                        n_tmp[k] = {1'b0, r_cached ? r_work_cnt[k] : r_base_cnt[k]};
                                    end
                                end
                            end
                        end
                        CMD_READ: begin
                            if (rd_bad) n_out.status = ST_RANGE;
                            else        n_out_valid = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_out = '{read_value: work_rdata, index_count: r_work_cnt[r_sm],
                          current_level: r_level, status: ST_OK};
            end
            S_FIT_RD: begin
                hdr_raddr = r_s[SPL_W-1:0];
                if (!fit_more) begin
                    n_s = r_from;
                    n_cp_sm = '0;
                    n_cp_i = '0;
                    if (!r_cached) n_work_cnt = r_base_cnt;
                end
            end
            S_FIT_CHK: begin
                if (fit_fail) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_tmp[hdr_rdata.sub] = fit_sum;
                    n_s = r_s + LVL_W'(1);
                end
            end
            S_CP_RD: begin
                if (!cp_more && !cp_last) begin
                    n_cp_sm = r_cp_sm + SUB_W'(1);
                    n_cp_i = '0;
                end
            end
            S_CP_WR: begin
                work_we = 1'b1;
                work_waddr = {r_cp_sm, r_cp_i[IDX_W-1:0]};
                work_wdata = base_rdata;
                n_cp_i = r_cp_i + CNT_W'(1);
            end
            S_SPL_RD: begin
                if (!spl_more) begin
                    n_level = r_target;
                    n_cached = 1'b1;
                    n_status = r_ok ? ST_OK : ST_UNMATCHED;
                end
            end
            S_SPL_HDR: begin
                n_h = hdr_rdata;
                n_cnt = r_work_cnt[hdr_rdata.sub];
                n_bound = r_work_cnt[hdr_rdata.sub];
                n_j = '0;
            end
            S_ADD_RD: begin
                n_zero = add_idx >= (ST_W+1)'(MAX_ADDITIONS);
                if (!add_more) n_j = '0;
            end
            S_ADD_W0: begin
                n_addw = r_zero ? '0 : add_rdata;
                work_we = 1'b1;
                work_wdata = r_zero ? '0 : add_rdata.a;
            end
            S_ADD_W1: begin
                work_we = 1'b1;
                work_waddr = {r_h.sub, IDX_W'(r_cnt + CNT_W'(1))};
                work_wdata = r_addw.b;
            end
            S_ADD_W2: begin
                work_we = 1'b1;
                work_waddr = {r_h.sub, IDX_W'(r_cnt + CNT_W'(2))};
                work_wdata = r_addw.c;
                n_cnt = r_cnt + CNT_W'(3);
                n_j = r_j + 8'd1;
            end
            S_MV_RD: begin
                n_zero = mov_idx >= (ST_W+1)'(MAX_MOVES);
            end
            S_MV_LAT: begin
                if (r_fwd) begin
                    n_p = mv.pat;
                    n_old = mv.fv;
                    n_new = mv.tv;
                end else begin
                    // undo: pattern carries to in place of from
                    n_p.a = (mv.pat.a == mv.fv) ? mv.tv : mv.pat.a;
                    n_p.b = (mv.pat.b == mv.fv) ? mv.tv : mv.pat.b;
                    n_p.c = (mv.pat.c == mv.fv) ? mv.tv : mv.pat.c;
                    n_old = mv.tv;
                    n_new = mv.fv;
                end
                n_i = '0;
                if (r_bound < CNT_W'(3)) begin
                    n_ok = 1'b0;
                    n_j = r_j + 8'd1;
                end
            end
            S_TRI_RD0: begin
                work_raddr = {r_h.sub, r_i[IDX_W-1:0]};
            end
            S_TRI_RD1: begin
                work_raddr = {r_h.sub, IDX_W'(r_i + CNT_W'(1))};
                n_t0 = work_rdata;
            end
            S_TRI_RD2: begin
                work_raddr = {r_h.sub, IDX_W'(r_i + CNT_W'(2))};
                n_t1 = work_rdata;
            end
            S_TRI_CHK: begin
                n_t2 = work_rdata;
                if (tri_match) begin
                    work_we = (r_t0 == r_old);
                    work_waddr = {r_h.sub, r_i[IDX_W-1:0]};
                    n_done = (r_t0 == r_old) || (r_t1 == r_old) || (work_rdata == r_old);
                end else if (tri_more) begin
                    n_i = r_i + CNT_W'(3);
                end else begin
                    n_ok = 1'b0;
                    n_j = r_j + 8'd1;
                end
            end
            S_TRI_W1: begin
                work_we = (r_t1 == r_old);
                work_waddr = {r_h.sub, IDX_W'(r_i + CNT_W'(1))};
            end
            S_TRI_W2: begin
                work_we = (r_t2 == r_old);
                work_waddr = {r_h.sub, IDX_W'(r_i + CNT_W'(2))};
                if (!r_done) n_ok = 1'b0;
                n_j = r_j + 8'd1;
            end
            S_SPL_END: begin
                if (r_fwd) begin
                    n_work_cnt[r_h.sub] = r_cnt;
                    n_s = r_s + LVL_W'(1);
                end else begin
                    // backward count saturates at zero
                    n_work_cnt[r_h.sub] = (r_work_cnt[r_h.sub] > CNT_W'(drop)) ?
                                          r_work_cnt[r_h.sub] - CNT_W'(drop) : '0;
                    n_s = r_s - LVL_W'(1);
                end
            end
            S_POST: begin
                n_out_valid = 1'b1;
                n_out = '{read_value: '0, index_count: r_work_cnt[r_sm],
                          current_level: r_level, status: r_status};
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < SUBMESHES; k++) begin
                r_base_cnt[k] <= '0;
                r_work_cnt[k] <= '0;
            end
            r_splits    <= '0;
            r_adds      <= '0;
            r_movs      <= '0;
            r_level     <= '0;
            r_cached    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base_cnt  <= n_base_cnt;
            r_work_cnt  <= n_work_cnt;
            r_splits    <= n_splits;
            r_adds      <= n_adds;
            r_movs      <= n_movs;
            r_level     <= n_level;
            r_cached    <= n_cached;
            r_out_valid <= n_out_valid;
        end
    end

    // walk and payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_tmp <= n_tmp;  r_out <= n_out;
        r_sm <= n_sm;  r_target <= n_target;  r_s <= n_s;  r_from <= n_from;
        r_fwd <= n_fwd;  r_ok <= n_ok;  r_done <= n_done;  r_zero <= n_zero;
        r_status <= n_status;  r_cp_sm <= n_cp_sm;  r_cp_i <= n_cp_i;
        r_h <= n_h;  r_cnt <= n_cnt;  r_bound <= n_bound;  r_i <= n_i;  r_j <= n_j;
        r_p <= n_p;  r_addw <= n_addw;  r_old <= n_old;  r_new <= n_new;
        r_t0 <= n_t0;  r_t1 <= n_t1;  r_t2 <= n_t2;
    end

endmodule

// ===== hdl/pmle_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module pmle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
